// ----- design/sample_adaptive_entropy_encoder_core_assert.svh -----
// Assertion macros used by the checker file of the entropy encoder core.
`ifndef SAMPLE_ADAPTIVE_ENTROPY_ENCODER_CORE_ASSERT_SVH
`define SAMPLE_ADAPTIVE_ENTROPY_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside of reset.
`define SAEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside of reset.
`define SAEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/saec_pkg.sv -----
`timescale 1ns / 1ps

package saec_pkg;

  // Field widths of the transactions.
  localparam int unsigned SampleW = 32;
  localparam int unsigned BandW   = 8;
  localparam int unsigned CodeW   = 64;
  localparam int unsigned LenW    = 7;
  localparam int unsigned NumBandCodes = 1 << BandW;

  // Per-band statistics word: counter above accumulator.
  localparam int unsigned CntW  = 11;
  localparam int unsigned AccW  = 44;
  localparam int unsigned StatW = CntW + AccW;
  localparam int unsigned SumW  = AccW + 1;

  // Largest code parameter k (dynamic range 32 minus two).
  localparam int unsigned KMax = 30;
  localparam int unsigned KW   = 5;

  // Arithmetic constants of the statistics.
  localparam int unsigned BiasMul   = 49;
  localparam int unsigned BiasShift = 7;
  localparam int unsigned InitMul   = 3;
  localparam int unsigned InitShift = 6;

  // Default sizes of the block.
  localparam int unsigned NUM_BANDS   = 256;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DYN_RANGE,
    CFG_UNARY_LIMIT,
    CFG_INIT_CNT_EXP,
    CFG_INIT_K,
    CFG_RESCALE_EXP
  } saec_cfg_idx_e;

  // Register reset values and legal ranges.
  localparam logic [5:0] DYN_RANGE_RST   = 6'd16;
  localparam logic [5:0] DYN_RANGE_MIN   = 6'd2;
  localparam logic [5:0] DYN_RANGE_MAX   = 6'd32;
  localparam logic [5:0] UNARY_LIMIT_RST = 6'd18;
  localparam logic [5:0] UNARY_LIMIT_MIN = 6'd8;
  localparam logic [5:0] UNARY_LIMIT_MAX = 6'd32;
  localparam logic [3:0] INIT_CNT_RST    = 4'd1;
  localparam logic [3:0] INIT_CNT_MIN    = 4'd1;
  localparam logic [3:0] INIT_CNT_MAX    = 4'd8;
  localparam logic [4:0] INIT_K_RST      = 5'd3;
  localparam logic [4:0] INIT_K_MAX      = 5'd30;
  localparam logic [3:0] RESCALE_RST     = 4'd6;
  localparam logic [3:0] RESCALE_MIN     = 4'd4;
  localparam logic [3:0] RESCALE_MAX     = 4'd11;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [BandW-1:0]   band;
    logic               first_in_band;
  } saec_in_t;

  typedef struct packed {
    logic [CodeW-1:0] code_bits;
    logic [LenW-1:0]  code_length;
  } saec_out_t;

  // Clamped configuration handed from the front end to the back end.
  typedef struct packed {
    logic [5:0] dyn_range;
    logic [5:0] unary_limit;
    logic [3:0] init_cnt_exp;
    logic [4:0] init_k;
    logic [3:0] rescale_exp;
  } saec_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_KSEL,
    ST_EMIT
  } saec_state_e;

endpackage

// ----- design/saec_ram.sv -----
`timescale 1ns / 1ps

module saec_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/saec_fifo.sv -----
`timescale 1ns / 1ps

module saec_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update; the users never push when full or pop when empty.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/saec_front.sv -----
`timescale 1ns / 1ps

module saec_front #(
  parameter int unsigned NumBands = saec_pkg::NUM_BANDS,
  parameter int unsigned AddrW    = (NumBands > 1) ? $clog2(NumBands) : 1,
  parameter int unsigned EntryW   = 1 + saec_pkg::SampleW + AddrW
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  saec_pkg::saec_in_t              in_data_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [saec_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [saec_pkg::CfgDataW-1:0]   cfg_data_i,
  output saec_pkg::saec_cfg_t             cfg_o,
  output logic                            push_o,
  output logic [EntryW-1:0]               entry_o,
  input  logic                            full_i
);

  import saec_pkg::*;

  typedef logic [AddrW-1:0] band_map_t [NumBandCodes];

  // Band code to statistics address, wrapping at the number of bands.
  function automatic band_map_t build_band_map();
    band_map_t   m;
    int unsigned r;
    r = 0;
    for (int i = 0; i < NumBandCodes; i++) begin
      m[i] = AddrW'(r);
      r = (r + 1 == NumBands) ? 0 : r + 1;
    end
    return m;
  endfunction

  localparam band_map_t BandMap = build_band_map();

  logic [5:0] dyn_range_q;
  logic [5:0] unary_limit_q;
  logic [3:0] init_cnt_q;
  logic [4:0] init_k_q;
  logic [3:0] rescale_q;

  // Configuration registers; writes to indexes past the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_range_q   <= DYN_RANGE_RST;
      unary_limit_q <= UNARY_LIMIT_RST;
      init_cnt_q    <= INIT_CNT_RST;
      init_k_q      <= INIT_K_RST;
      rescale_q     <= RESCALE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DYN_RANGE:    dyn_range_q   <= cfg_data_i[5:0];
        CFG_UNARY_LIMIT:  unary_limit_q <= cfg_data_i[5:0];
        CFG_INIT_CNT_EXP: init_cnt_q    <= cfg_data_i[3:0];
        CFG_INIT_K:       init_k_q      <= cfg_data_i[4:0];
        CFG_RESCALE_EXP:  rescale_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Register outputs saturate to their legal ranges.
  always_comb begin
    cfg_o.dyn_range = (dyn_range_q < DYN_RANGE_MIN) ? DYN_RANGE_MIN :
                      (dyn_range_q > DYN_RANGE_MAX) ? DYN_RANGE_MAX : dyn_range_q;
    cfg_o.unary_limit = (unary_limit_q < UNARY_LIMIT_MIN) ? UNARY_LIMIT_MIN :
                        (unary_limit_q > UNARY_LIMIT_MAX) ? UNARY_LIMIT_MAX :
                        unary_limit_q;
    cfg_o.init_cnt_exp = (init_cnt_q < INIT_CNT_MIN) ? INIT_CNT_MIN :
                         (init_cnt_q > INIT_CNT_MAX) ? INIT_CNT_MAX : init_cnt_q;
    cfg_o.init_k = (init_k_q > INIT_K_MAX) ? INIT_K_MAX : init_k_q;
    cfg_o.rescale_exp = (rescale_q < RESCALE_MIN) ? RESCALE_MIN :
                        (rescale_q > RESCALE_MAX) ? RESCALE_MAX : rescale_q;
  end

  // Accept a transaction whenever the queue has room and classify it.
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign entry_o    = {in_data_i.first_in_band, in_data_i.sample, BandMap[in_data_i.band]};

endmodule

// ----- design/saec_back.sv -----
`timescale 1ns / 1ps

module saec_back #(
  parameter int unsigned NumBands = saec_pkg::NUM_BANDS,
  parameter int unsigned AddrW    = (NumBands > 1) ? $clog2(NumBands) : 1,
  parameter int unsigned EntryW   = 1 + saec_pkg::SampleW + AddrW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  saec_pkg::saec_cfg_t cfg_i,
  input  logic [EntryW-1:0]   entry_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output saec_pkg::saec_out_t out_data_o
);

  import saec_pkg::*;

  saec_state_e state_q, state_d;

  logic               entry_first;
  logic [SampleW-1:0] entry_sample;
  logic [AddrW-1:0]   entry_addr;

  logic               first_q;
  logic [SampleW-1:0] sample_q;
  logic [AddrW-1:0]   addr_q;
  logic [CntW-1:0]    cnt_q;
  logic [AccW-1:0]    acc_q;
  logic [SumW-1:0]    sum_q;
  logic [KW-1:0]      k_q;
  logic [KW-1:0]      k_sel;

  logic               ram_re, ram_we;
  logic [StatW-1:0]   ram_rdata, ram_wdata;
  logic [CntW-1:0]    rd_cnt;
  logic [AccW-1:0]    rd_acc;
  logic [16:0]        bias_prod;

  logic [KMax:0]      ge;
  logic [KW-1:0]      k_raw;
  logic [KW-1:0]      k_limit;

  logic               out_free, load;
  logic               out_valid_q;
  saec_out_t          out_q, out_d;

  logic [SampleW-1:0] unary;
  logic               escape;
  logic [CodeW-1:0]   dmask, kmask, raw_bits;
  logic [11:0]        cnt_limit;
  logic [SumW-1:0]    acc_sum, acc_sum_inc;
  logic [37:0]        init_base;
  logic [45:0]        init_prod;
  logic [CntW-1:0]    wr_cnt;
  logic [AccW-1:0]    wr_acc;

  assign {entry_first, entry_sample, entry_addr} = entry_i;

  // Band statistics: counter above accumulator.
  saec_ram #(
    .Width (StatW),
    .Depth (NumBands)
  ) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (entry_addr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer: take, read stats and find k (skipped for first samples), emit and write back.
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    ram_re  = 1'b0;
    ram_we  = 1'b0;
    load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          ram_re  = !entry_first;
          state_d = entry_first ? ST_EMIT : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_KSEL;
      end
      ST_KSEL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Biased accumulator from the statistics just read.
  assign rd_cnt    = ram_rdata[StatW-1 -: CntW];
  assign rd_acc    = ram_rdata[AccW-1:0];
  assign bias_prod = 17'(rd_cnt) * 17'(BiasMul);

  // k is the largest counter shift at or below the biased sum, limited to dyn_range - 2.
  assign k_limit = KW'(cfg_i.dyn_range - 6'd2);

  always_comb begin
    for (int j = 0; j <= KMax; j++) begin
      ge[j] = ((SumW'(cnt_q)) << j) <= sum_q;
    end
    k_raw = '0;
    for (int j = 1; j <= KMax; j++) begin
      if (ge[j]) begin
        k_raw = KW'(j);
      end
    end
    if (cnt_q == '0) begin
      k_raw = '0;
    end
    k_sel = (k_raw > k_limit) ? k_limit : k_raw;
  end

  // Item and statistics registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      first_q  <= entry_first;
      sample_q <= entry_sample;
      addr_q   <= entry_addr;
    end
    if (state_q == ST_READ) begin
      cnt_q <= rd_cnt;
      acc_q <= rd_acc;
      sum_q <= SumW'(rd_acc) + SumW'(bias_prod[16:BiasShift]);
    end
    if (state_q == ST_KSEL) begin
      k_q <= k_sel;
    end
  end

  // Codeword: raw for a band's first sample, escaped when the unary part runs long.
  always_comb begin
    unary    = sample_q >> k_q;
    escape   = unary >= SampleW'(cfg_i.unary_limit);
    dmask    = (CodeW'(1) << cfg_i.dyn_range) - CodeW'(1);
    kmask    = (CodeW'(1) << k_q) - CodeW'(1);
    raw_bits = CodeW'(sample_q) & dmask;
    if (first_q) begin
      out_d.code_bits   = raw_bits;
      out_d.code_length = LenW'(cfg_i.dyn_range);
    end else if (escape) begin
      out_d.code_bits   = raw_bits;
      out_d.code_length = LenW'(cfg_i.unary_limit) + LenW'(cfg_i.dyn_range);
    end else begin
      out_d.code_bits   = (CodeW'(1) << k_q) | (CodeW'(sample_q) & kmask);
      out_d.code_length = LenW'(unary[5:0]) + LenW'(k_q) + LenW'(1);
    end
  end

  // Statistics update: seeding for a band's first sample, with halving at the counter limit.
  always_comb begin
    cnt_limit   = (12'(1) << cfg_i.rescale_exp) - 12'd1;
    acc_sum     = SumW'(acc_q) + SumW'(sample_q);
    acc_sum_inc = acc_sum + SumW'(1);
    init_base   = (38'(InitMul) << (6'(cfg_i.init_k) + 6'(InitShift))) - 38'(BiasMul);
    init_prod   = 46'(init_base) << cfg_i.init_cnt_exp;
    if (first_q) begin
      wr_cnt = CntW'(1) << cfg_i.init_cnt_exp;
      wr_acc = AccW'(init_prod >> BiasShift);
    end else if (12'(cnt_q) < cnt_limit) begin
      wr_cnt = cnt_q + CntW'(1);
      wr_acc = acc_sum[AccW-1:0];
    end else begin
      wr_cnt = CntW'((12'(cnt_q) + 12'd1) >> 1);
      wr_acc = acc_sum_inc[SumW-1:1];
    end
  end

  assign ram_wdata = {wr_cnt, wr_acc};

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/sample_adaptive_entropy_encoder_core.sv -----
`timescale 1ns / 1ps
// An accepted transaction is queued, then taken by the back end. The first sample of
// a band goes straight to the output register once that is free; any other sample
// first passes the statistics RAM read and the k search. The back end takes another
// transaction only after the last is emitted and written back; the queue holds others.
// Reset: clears the queue, the sequencer and the output valid, and loads register defaults;
// band statistics stay undefined until the first sample of that band writes them.

module sample_adaptive_entropy_encoder_core #(
  parameter int unsigned NumBands   = saec_pkg::NUM_BANDS,
  parameter int unsigned QueueDepth = saec_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  saec_pkg::saec_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output saec_pkg::saec_out_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [saec_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [saec_pkg::CfgDataW-1:0] cfg_data_i
);

  import saec_pkg::*;

  localparam int unsigned AddrW  = (NumBands > 1) ? $clog2(NumBands) : 1;
  localparam int unsigned EntryW = 1 + SampleW + AddrW;

  saec_cfg_t         cfg;
  logic              push, pop, full, empty;
  logic [EntryW-1:0] push_entry, pop_entry;

  // Front end: configuration and intake.
  saec_front #(
    .NumBands (NumBands),
    .AddrW    (AddrW),
    .EntryW   (EntryW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .push_o      (push),
    .entry_o     (push_entry),
    .full_i      (full)
  );

  // Queue between intake and coding.
  saec_fifo #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .empty_o (empty)
  );

  // Back end: statistics and codeword generation.
  saec_back #(
    .NumBands (NumBands),
    .AddrW    (AddrW),
    .EntryW   (EntryW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .entry_i     (pop_entry),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- design/saec_checker.sv -----
`timescale 1ns / 1ps
`include "sample_adaptive_entropy_encoder_core_assert.svh"

module saec_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  saec_pkg::saec_out_t out_data_i
);

  import saec_pkg::*;

  // A stalled result stays offered.
  `SAEC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i, "result dropped while stalled")

  // A stalled result keeps its payload.
  `SAEC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && out_stall_i, $stable(out_data_i), "result changed while stalled")

  // Codeword length stays within one to sixty-four bits.
  `SAEC_ASSERT_NOW(a_len_range, clk_i, rst_ni, out_valid_i, (out_data_i.code_length != '0) && (out_data_i.code_length <= LenW'(CodeW)), "code length out of range")

  // No codeword bit is set above its length.
  `SAEC_ASSERT_NOW(a_bits_fit, clk_i, rst_ni, out_valid_i, (out_data_i.code_bits >> out_data_i.code_length) == '0, "code bits above code length")

endmodule

bind sample_adaptive_entropy_encoder_core saec_checker u_saec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import saec_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned IdleCycles = 8;
  localparam int unsigned RandomItemsPerPhase = 175;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;
  localparam longint unsigned AccMask = (64'd1 << AccW) - 64'd1;

  // Clock, reset and the signals driven into the block.
  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  saec_in_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  saec_out_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Predictor copy of the registers, as written.
  logic [5:0] cfg_dyn_range = DYN_RANGE_RST;
  logic [5:0] cfg_unary_limit = UNARY_LIMIT_RST;
  logic [3:0] cfg_init_cnt_exp = INIT_CNT_RST;
  logic [4:0] cfg_init_k = INIT_K_RST;
  logic [3:0] cfg_rescale_exp = RESCALE_RST;

  // Predictor copy of the per-band statistics.
  logic [CntW-1:0] band_cnt [NUM_BANDS];
  logic [AccW-1:0] band_acc [NUM_BANDS];
  bit              band_ready [NUM_BANDS];

  // Code words predicted for accepted residuals, oldest first.
  saec_out_t   pending_codes [$];
  saec_out_t   expected_code;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Traffic shaping knobs in percent, with burst and stall run counters and the band pool.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned burst_left = 0;
  int unsigned stall_run = 0;
  int unsigned band_pool [4];

  sample_adaptive_entropy_encoder_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Free-running clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Global watchdog on the run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sample_adaptive_entropy_encoder_core regression: fail");
      $finish;
    end
  end

  // The output side stalls in runs of random length.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_run = $urandom_range(1, 8);
      out_stall <= ($urandom_range(99) < stall_pct);
    end else begin
      stall_run--;
    end
  end

  // Compare every output transaction with the oldest predicted code word.
  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected code word: expected none, actual bits %h length %0d",
                 $time, out_data.code_bits, out_data.code_length);
        mismatch_count++;
      end else begin
        expected_code = pending_codes.pop_front();
        if (out_data.code_bits !== expected_code.code_bits) begin
          $display("%0t: code_bits mismatch: expected %h actual %h",
                   $time, expected_code.code_bits, out_data.code_bits);
          mismatch_count++;
        end
        if (out_data.code_length !== expected_code.code_length) begin
          $display("%0t: code_length mismatch: expected %0d actual %0d",
                   $time, expected_code.code_length, out_data.code_length);
          mismatch_count++;
        end
      end
    end
  end

  function automatic longint unsigned clamp_to(longint unsigned v, longint unsigned lo,
                                               longint unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Encode one residual and advance the band statistics.
  function automatic saec_out_t encode_residual(saec_in_t item);
    longint unsigned d, umax, ice, ik, rce, s, dmask, c, a, k, q, u, bits, len;
    int unsigned b;
    saec_out_t res;
    d = clamp_to(cfg_dyn_range, DYN_RANGE_MIN, DYN_RANGE_MAX);
    umax = clamp_to(cfg_unary_limit, UNARY_LIMIT_MIN, UNARY_LIMIT_MAX);
    ice = clamp_to(cfg_init_cnt_exp, INIT_CNT_MIN, INIT_CNT_MAX);
    ik = clamp_to(cfg_init_k, 0, INIT_K_MAX);
    rce = clamp_to(cfg_rescale_exp, RESCALE_MIN, RESCALE_MAX);
    s = item.sample;
    b = item.band % NUM_BANDS;
    dmask = (64'd1 << d) - 64'd1;
    if (item.first_in_band) begin
      // Seed the band and send the sample raw.
      c = 64'd1 << ice;
      band_cnt[b] = c;
      band_acc[b] = ((c * ((longint'(InitMul) << (ik + InitShift)) - BiasMul)) >> BiasShift)
                    & AccMask;
      bits = s & dmask;
      len = d;
    end else begin
      c = band_cnt[b];
      a = band_acc[b];
      k = 0;
      if (c != 0) begin
        q = (a + ((BiasMul * c) >> BiasShift)) / c;
        while (q > 1) begin
          q = q >> 1;
          k++;
        end
      end
      if (k > d - 2) k = d - 2;
      u = s >> k;
      if (u < umax) begin
        bits = (64'd1 << k) | (s & ((64'd1 << k) - 64'd1));
        len = u + 1 + k;
      end else begin
        // Escape: u_max zeros, then the sample in D bits.
        bits = s & dmask;
        len = umax + d;
      end
      if (c < (64'd1 << rce) - 64'd1) begin
        band_acc[b] = (a + s) & AccMask;
        band_cnt[b] = c + 1;
      end else begin
        band_acc[b] = ((a + s + 1) >> 1) & AccMask;
        band_cnt[b] = (c + 1) >> 1;
      end
    end
    res.code_bits = bits;
    res.code_length = len[LenW-1:0];
    return res;
  endfunction

  // Offer one residual in bursts, and predict it once it is accepted.
  task automatic send_residual(logic [SampleW-1:0] sample, logic [BandW-1:0] band,
                               logic first);
    int unsigned gap;
    saec_in_t item;
    gap = 0;
    item.sample = sample;
    item.band = band;
    item.first_in_band = first;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    pending_codes.push_back(encode_residual(item));
    if (first) band_ready[band] = 1'b1;
    burst_left--;
  endtask

  // Stop sending and wait until every predicted code word has come out.
  task automatic wait_for_codes();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (IdleCycles) @(posedge clk);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_DYN_RANGE:    cfg_dyn_range = data[5:0];
      CFG_UNARY_LIMIT:  cfg_unary_limit = data[5:0];
      CFG_INIT_CNT_EXP: cfg_init_cnt_exp = data[3:0];
      CFG_INIT_K:       cfg_init_k = data[4:0];
      CFG_RESCALE_EXP:  cfg_rescale_exp = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reprogram all five registers once the block has drained.
  task automatic set_registers(logic [CfgDataW-1:0] dyn, logic [CfgDataW-1:0] ulim,
                               logic [CfgDataW-1:0] ice, logic [CfgDataW-1:0] ik,
                               logic [CfgDataW-1:0] rce);
    wait_for_codes();
    write_register(CFG_DYN_RANGE, dyn);
    write_register(CFG_UNARY_LIMIT, ulim);
    write_register(CFG_INIT_CNT_EXP, ice);
    write_register(CFG_INIT_K, ik);
    write_register(CFG_RESCALE_EXP, rce);
  endtask

  // Mostly runs on a few seeded bands, with reseeds and stray bands mixed in.
  task automatic run_random_items(int unsigned count);
    logic [BandW-1:0]   band;
    logic               first;
    logic [SampleW-1:0] sample;
    longint unsigned    d, dmask;
    int unsigned        r, w;
    for (int i = 0; i < 4; i++) band_pool[i] = $urandom_range(NUM_BANDS - 1);
    d = clamp_to(cfg_dyn_range, DYN_RANGE_MIN, DYN_RANGE_MAX);
    dmask = (64'd1 << d) - 64'd1;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 6) begin
        band = $urandom_range(NUM_BANDS - 1);
        first = 1'b1;
      end else if (r < 12) begin
        band = $urandom_range(NUM_BANDS - 1);
        first = !band_ready[band];
      end else begin
        band = band_pool[$urandom_range(3)];
        first = !band_ready[band] || ($urandom_range(99) < 3);
      end
      r = $urandom_range(99);
      if (r < 8) begin
        sample = '0;
      end else if (r < 14) begin
        sample = dmask;
      end else if (r < 24) begin
        // Full width, usually at or above 2^D.
        sample = $urandom;
      end else begin
        w = $urandom_range(0, d);
        sample = (w == 0) ? '0 : ($urandom >> (32 - w));
      end
      send_residual(sample, band, first);
    end
  endtask

  task automatic test_reset_defaults();
    gap_pct = 20;
    stall_pct = 20;
    send_residual(32'h0000_FFFF, 8'd0, 1'b1);
    send_residual(32'h0000_0000, 8'd255, 1'b1);
    send_residual(32'h0000_0000, 8'd0, 1'b0);
    send_residual(32'h0000_FFFF, 8'd0, 1'b0);
    // Above 2^D: escaped with only the low D bits.
    send_residual(32'hDEAD_BEEF, 8'd255, 1'b0);
    send_residual(32'd40, 8'd0, 1'b0);
  endtask

  task automatic test_register_saturation();
    // Below the legal ranges, and initial_k above its range.
    set_registers(32'hFFFF_FFC0, 32'd0, 32'd0, 32'd31, 32'd0);
    write_register(CfgIdxUnused, 32'hFFFF_FFFF);
    send_residual(32'h0000_0007, 8'd17, 1'b1);
    send_residual(32'd1, 8'd17, 1'b0);
    send_residual(32'hFFFF_FFFF, 8'd17, 1'b0);
    // Above the legal ranges.
    set_registers(32'h0000_003F, 32'd63, 32'd15, 32'd31, 32'd15);
    send_residual(32'hFFFF_FFFF, 8'd200, 1'b1);
    send_residual(32'hFFFF_FFFF, 8'd200, 1'b0);
    send_residual(32'h0000_0000, 8'd200, 1'b0);
  endtask

  task automatic test_zero_quotient_rescale();
    // Zeros leave the accumulator at or below the counter, so k stays zero,
    // and the counter then reaches its limit and both values halve.
    set_registers(32'd32, 32'd32, 32'd2, 32'd0, 32'd4);
    send_residual(32'd0, 8'd9, 1'b1);
    repeat (12) send_residual(32'd0, 8'd9, 1'b0);
    // With k at zero this escapes to the longest code word.
    send_residual(32'hFFFF_FFFF, 8'd9, 1'b0);
  endtask

  task automatic test_random_defaults();
    set_registers(DYN_RANGE_RST, UNARY_LIMIT_RST, INIT_CNT_RST, INIT_K_RST, RESCALE_RST);
    gap_pct = 0;
    stall_pct = 0;
    run_random_items(RandomItemsPerPhase);
  endtask

  task automatic test_random_minimum();
    set_registers(DYN_RANGE_MIN, UNARY_LIMIT_MIN, INIT_CNT_MIN, 32'd0, RESCALE_MIN);
    gap_pct = 30;
    stall_pct = 30;
    run_random_items(RandomItemsPerPhase);
  endtask

  task automatic test_random_maximum();
    set_registers(DYN_RANGE_MAX, UNARY_LIMIT_MAX, INIT_CNT_MAX, INIT_K_MAX, RESCALE_MAX);
    gap_pct = 50;
    stall_pct = 50;
    run_random_items(RandomItemsPerPhase);
  endtask

  task automatic test_random_mixed();
    set_registers($urandom_range(2, 32), $urandom_range(8, 32), $urandom_range(1, 8),
                  $urandom_range(0, 30), $urandom_range(4, 11));
    gap_pct = $urandom_range(0, 60);
    stall_pct = $urandom_range(0, 60);
    run_random_items(RandomItemsPerPhase / 2);
    // Let the pipeline empty completely before the second half.
    wait_for_codes();
    run_random_items(RandomItemsPerPhase - RandomItemsPerPhase / 2);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_saturation();
    test_zero_quotient_rescale();
    test_random_defaults();
    test_random_minimum();
    test_random_maximum();
    test_random_mixed();

    wait_for_codes();
    if (mismatch_count == 0) begin
      $display("sample_adaptive_entropy_encoder_core regression: pass");
    end else begin
      $display("sample_adaptive_entropy_encoder_core regression: fail");
    end
    $finish;
  end

endmodule
